// ===== src/rrwt_pkg.sv =====
// rrwt_pkg: shared types and codes for the receive release window tracker
// no dependencies; imported by the core, its checker and the testbench files
package rrwt_pkg;

	typedef enum logic [1:0] {
		KIND_RELEASE  = 2'd0,
		KIND_TAKE_ACK = 2'd1,
		KIND_ACK_FAIL = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_RECORDED      = 2'd0,
		ST_ADVANCED      = 2'd1,
		ST_DUPLICATE     = 2'd2,
		ST_OUT_OF_WINDOW = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_LO   = 8'b00000010,
		S_HI   = 8'b00000100,
		S_BIT  = 8'b00001000,
		S_WALK = 8'b00010000,
		S_ACK  = 8'b00100000,
		S_ACK2 = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;

	localparam int SEQ_W = 64;
	localparam int HELD_W = 9;

endpackage

// ===== src/receive_release_window_tracker_core.sv =====
// receive_release_window_tracker_core: receive ring bitmap with cumulative ack tracking
// depends on rrwt_pkg; one sequencer around a shared 64-bit adder
//
// usage
//   an item (kind, sequence_req) is taken when start is high and busy is low.
//   each item not cut short by cfg_we yields one result, with done high for one cycle;
//   the receiver cannot stall, so results are never held back.
//   cfg_we writes epoch_start; it clears the bitmap and tracking state at once.
//   ring slots are counted from the written value, and busy is low after it
// states per kind, in order from the accept up to S_DONE, which shows the result
//   release, below the end: S_LO; out of window: S_LO, S_HI
//   release, slot already set: S_LO, S_HI, S_BIT; recorded or advanced: S_LO, S_HI,
//   S_BIT, S_WALK, where S_WALK steps the end over each contiguous set slot and each
//   advance step is one pass of the shared adder
//   take-ack: S_ACK, S_ACK2, or S_ACK alone while the end still equals epoch_start
//   ack-failed and unused kind: straight to S_DONE
//   after done the block returns to idle, where the next item is taken at the earliest
// reset
//   arst_n clears the bitmap, end, counts and ack state; epoch_start reads as 0
//   and the block is ready at once
module receive_release_window_tracker_core #(
	parameter int WINDOW_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [63:0] sequence_req,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  release_status,
	output logic        ack_valid,
	output logic [63:0] ack_value,
	output logic [63:0] contiguous_end,
	output logic [8:0]  held_count
);
	import rrwt_pkg::*;

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam logic [SLOT_W:0] DEPTH_S = (SLOT_W + 1)'(WINDOW_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [SEQ_W-1:0] DEPTH_W = SEQ_W'(WINDOW_SLOTS);

	state_t                  state_q;
	logic [SEQ_W-1:0]        seq_q;
	logic [SEQ_W-1:0]        diff_q;
	logic [SEQ_W-1:0]        cand_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [SEQ_W-1:0]        epoch_q;
	logic [SEQ_W-1:0]        end_q;
	logic [SLOT_W-1:0]       end_slot_q;
	logic [WINDOW_SLOTS-1:0] bitmap_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SEQ_W-1:0]        last_ack_q;
	logic                    ack_out_q;
	logic                    moved_q;
	status_t                 status_q;
	logic                    ack_valid_q;
	logic [SEQ_W-1:0]        ack_value_q;

	logic [SEQ_W-1:0]        alu_a;
	logic [SEQ_W-1:0]        alu_b;
	logic                    alu_cin;
	logic [SEQ_W:0]          alu_sum;
	logic [SLOT_W:0]         slot_sum;
	logic [SLOT_W:0]         slot_wrap;
	logic [SLOT_W-1:0]       end_slot_inc;
	logic                    accept;

	assign accept = start && (state_q == S_IDLE);

	// shared adder
	always_comb begin
		unique case (state_q)
			S_LO: begin
				alu_a   = seq_q;
				alu_b   = ~end_q;
				alu_cin = 1'b1;
			end
			S_HI: begin
				alu_a   = end_q;
				alu_b   = DEPTH_W;
				alu_cin = 1'b0;
			end
			S_ACK: begin
				alu_a   = end_q;
				alu_b   = '1;
				alu_cin = 1'b0;
			end
			default: begin
				alu_a   = end_q;
				alu_b   = '0;
				alu_cin = 1'b1;
			end
		endcase
	end

	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (SEQ_W + 1)'(alu_cin);

	// ring slot of the released sequence, from its offset past the end
	assign slot_sum  = {1'b0, end_slot_q} + {1'b0, diff_q[SLOT_W-1:0]};
	assign slot_wrap = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;

	assign end_slot_inc = (end_slot_q == LAST_SLOT) ? '0 : end_slot_q + SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			epoch_q     <= '0;
			end_q       <= '0;
			end_slot_q  <= '0;
			bitmap_q    <= '0;
			cnt_q       <= '0;
			last_ack_q  <= '0;
			ack_out_q   <= 1'b0;
			moved_q     <= 1'b0;
			status_q    <= ST_RECORDED;
			ack_valid_q <= 1'b0;
			ack_value_q <= '0;
		end else if (cfg_we) begin
			state_q    <= S_IDLE;
			epoch_q    <= cfg_wdata;
			end_q      <= cfg_wdata;
			end_slot_q <= '0;
			bitmap_q   <= '0;
			cnt_q      <= '0;
			last_ack_q <= '0;
			ack_out_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q    <= ST_RECORDED;
						ack_valid_q <= 1'b0;
						ack_value_q <= '0;
						moved_q     <= 1'b0;
						unique case (kind_t'(kind))
							KIND_RELEASE:  state_q <= S_LO;
							KIND_TAKE_ACK: state_q <= S_ACK;
							KIND_ACK_FAIL: begin
								ack_out_q <= 1'b0;
								state_q   <= S_DONE;
							end
							default:       state_q <= S_DONE;
						endcase
					end
				end
				S_LO: begin
					if (!alu_sum[SEQ_W]) begin
						status_q <= ST_DUPLICATE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_HI;
					end
				end
				S_HI: begin
					if (alu_sum[SEQ_W] || (diff_q >= DEPTH_W)) begin
						status_q <= ST_OUT_OF_WINDOW;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					if (bitmap_q[slot_q]) begin
						status_q <= ST_DUPLICATE;
						state_q  <= S_DONE;
					end else begin
						bitmap_q[slot_q] <= 1'b1;
						cnt_q            <= cnt_q + CNT_W'(1);
						state_q          <= S_WALK;
					end
				end
				S_WALK: begin
					if (bitmap_q[end_slot_q] && (cnt_q != '0)) begin
						bitmap_q[end_slot_q] <= 1'b0;
						cnt_q                <= cnt_q - CNT_W'(1);
						end_q                <= alu_sum[SEQ_W-1:0];
						end_slot_q           <= end_slot_inc;
						moved_q              <= 1'b1;
					end else begin
						status_q <= moved_q ? ST_ADVANCED : ST_RECORDED;
						state_q  <= S_DONE;
					end
				end
				S_ACK: begin
					state_q <= (end_q == epoch_q) ? S_DONE : S_ACK2;
				end
				S_ACK2: begin
					if (!(ack_out_q && (cand_q == last_ack_q))) begin
						last_ack_q  <= cand_q;
						ack_out_q   <= 1'b1;
						ack_valid_q <= 1'b1;
						ack_value_q <= cand_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= sequence_req;
		end
		if (state_q == S_LO) begin
			diff_q <= alu_sum[SEQ_W-1:0];
		end
		if (state_q == S_HI) begin
			slot_q <= slot_wrap[SLOT_W-1:0];
		end
		if (state_q == S_ACK) begin
			cand_q <= alu_sum[SEQ_W-1:0];
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = (state_q == S_DONE);
	assign release_status = status_q;
	assign ack_valid      = ack_valid_q;
	assign ack_value      = ack_value_q;
	assign contiguous_end = end_q;
	assign held_count     = HELD_W'(cnt_q);

endmodule

// ===== src/rrwt_checker.sv =====
// rrwt_checker: port-level assertions for receive_release_window_tracker_core
// depends on rrwt_pkg; attached to the core by the bind at the end of this file
module rrwt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        cfg_we,
	input logic [63:0] cfg_wdata,
	input logic        done,
	input logic [1:0]  release_status,
	input logic        ack_valid,
	input logic [63:0] ack_value,
	input logic [63:0] contiguous_end,
	input logic [8:0]  held_count
);
	import rrwt_pkg::*;

	// an accepted item keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// one result per item, never two in a row
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// an ack only comes from a take-ack item, whose status is recorded
	a_ack_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ack_valid) |-> (release_status == ST_RECORDED))
		else $error("ack with a release status");

	// no ack value without an ack
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ack_valid) |-> (ack_value == '0))
		else $error("ack value without ack valid");

	// epoch write restarts tracking at the written value
	a_epoch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (!busy && contiguous_end == $past(cfg_wdata) && held_count == '0))
		else $error("epoch write did not clear tracking state");

endmodule

bind receive_release_window_tracker_core rrwt_checker u_rrwt_checker (.*);

// ===== test/release_window_sb_pkg.sv =====
// release_window_sb_pkg: scoreboard for the receive release window tracker
// predicts each item from its own bitmap, end and ack state and checks results
// depends on rrwt_pkg
`timescale 1ns / 100ps

package release_window_sb_pkg;

	import rrwt_pkg::*;

	localparam int WINDOW_DEPTH = 256;

	typedef struct {
		status_t     status;
		logic        ack_valid;
		logic [63:0] ack_value;
		logic [63:0] cend;
		logic [8:0]  held;
	} window_result_t;

	class release_window_sb;
		logic [WINDOW_DEPTH-1:0] seen;
		logic [63:0]             epoch;
		logic [63:0]             end_ptr;
		logic [63:0]             last_ack;
		logic [8:0]              held;
		bit                      ack_armed;
		window_result_t          awaited[$];
		int                      errors;

		function new();
			errors = 0;
			restart(64'd0);
		endfunction

		function void restart(logic [63:0] first);
			epoch = first;
			seen = '0;
			end_ptr = first;
			held = '0;
			last_ack = '0;
			ack_armed = 1'b0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function status_t release_seq(logic [63:0] s);
			logic [64:0] limit;
			logic [63:0] start_end;
			limit = {1'b0, end_ptr} + 65'(WINDOW_DEPTH);
			if (s < end_ptr)
				return ST_DUPLICATE;
			if (limit[64] || s >= limit[63:0])
				return ST_OUT_OF_WINDOW;
			if (seen[s % 64'(WINDOW_DEPTH)])
				return ST_DUPLICATE;
			seen[s % 64'(WINDOW_DEPTH)] = 1'b1;
			held = held + 9'd1;
			start_end = end_ptr;
			// walk the end over contiguous set slots
			while (held != 0 && seen[end_ptr % 64'(WINDOW_DEPTH)]) begin
				seen[end_ptr % 64'(WINDOW_DEPTH)] = 1'b0;
				held = held - 9'd1;
				end_ptr = end_ptr + 64'd1;
			end
			return (end_ptr > start_end) ? ST_ADVANCED : ST_RECORDED;
		endfunction

		function void note_item(kind_t k, logic [63:0] s);
			window_result_t r;
			logic [63:0]    cand;
			r.status = ST_RECORDED;
			r.ack_valid = 1'b0;
			r.ack_value = '0;
			case (k)
				KIND_RELEASE: begin
					r.status = release_seq(s);
				end
				KIND_TAKE_ACK: begin
					if (end_ptr != epoch) begin
						cand = end_ptr - 64'd1;
						if (!(ack_armed && cand == last_ack)) begin
							last_ack = cand;
							ack_armed = 1'b1;
							r.ack_valid = 1'b1;
							r.ack_value = cand;
						end
					end
				end
				KIND_ACK_FAIL: begin
					ack_armed = 1'b0;
				end
				default: begin
				end
			endcase
			r.cend = end_ptr;
			r.held = held;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic av, logic [63:0] aval,
				logic [63:0] cend, logic [8:0] hc);
			window_result_t r;
			if (awaited.size() == 0) begin
				$error("result with no item awaiting it");
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (st !== r.status) begin
				$error("release_status expected %0d actual %0d", r.status, st);
				errors++;
			end
			if (av !== r.ack_valid) begin
				$error("ack_valid expected %0d actual %0d", r.ack_valid, av);
				errors++;
			end
			if (aval !== r.ack_value) begin
				$error("ack_value expected %h actual %h", r.ack_value, aval);
				errors++;
			end
			if (cend !== r.cend) begin
				$error("contiguous_end expected %h actual %h", r.cend, cend);
				errors++;
			end
			if (hc !== r.held) begin
				$error("held_count expected %0d actual %0d", r.held, hc);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== test/tb.sv =====
// tb: top-level testbench for receive_release_window_tracker_core
// directed window, duplicate and ack cases, then random phases over several epochs
// depends on rrwt_pkg and release_window_sb_pkg
`timescale 1ns / 100ps

module tb;

	import rrwt_pkg::*;
	import release_window_sb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [63:0] sequence_req;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        done;
	logic [1:0]  release_status;
	logic        ack_valid;
	logic [63:0] ack_value;
	logic [63:0] contiguous_end;
	logic [8:0]  held_count;

	release_window_sb sb;
	bit               idling_on;

	receive_release_window_tracker_core #(
		.WINDOW_SLOTS(WINDOW_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.sequence_req(sequence_req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.release_status(release_status),
		.ack_valid(ack_valid),
		.ack_value(ack_value),
		.contiguous_end(contiguous_end),
		.held_count(held_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(release_status, ack_valid, ack_value, contiguous_end,
					held_count);
			if (start && !busy)
				sb.note_item(kind_t'(kind), sequence_req);
		end
	end

	task automatic idle_burst();
		int n;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 14);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(kind_t k, logic [63:0] s);
		start <= 1'b1;
		kind <= k;
		sequence_req <= s;
		do @(posedge clk); while (busy);
		idle_burst();
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_epoch(logic [63:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.restart(v);
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_item();
		int          pick;
		logic [63:0] base;
		logic [63:0] s;
		kind_t       k;
		pick = $urandom_range(0, 99);
		base = sb.end_ptr;
		k = KIND_RELEASE;
		s = {$urandom, $urandom};
		if (pick < 45)
			s = base + 64'($urandom_range(0, 24));
		else if (pick < 58)
			s = base + 64'($urandom_range(0, WINDOW_DEPTH + 4));
		else if (pick < 64)
			s = base - 64'($urandom_range(1, 8));
		else if (pick < 69)
			k = KIND_RELEASE;
		else if (pick < 84)
			k = KIND_TAKE_ACK;
		else if (pick < 95)
			k = KIND_ACK_FAIL;
		else
			k = KIND_UNUSED;
		send_item(k, s);
	endtask

	initial begin
		logic [63:0] epochs[5];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_RELEASE;
		sequence_req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idling_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, epoch 0 after reset
		send_item(KIND_TAKE_ACK, 64'd0);
		send_item(KIND_RELEASE, 64'd0);
		send_item(KIND_TAKE_ACK, 64'd0);
		send_item(KIND_TAKE_ACK, 64'd0);
		send_item(KIND_ACK_FAIL, 64'd0);
		send_item(KIND_TAKE_ACK, 64'd0);
		send_item(KIND_RELEASE, 64'd5);
		send_item(KIND_RELEASE, 64'd5);
		send_item(KIND_RELEASE, 64'd0);
		send_item(KIND_RELEASE, 64'd257);
		send_item(KIND_RELEASE, 64'd256);
		send_item(KIND_RELEASE, '1);
		send_item(KIND_RELEASE, 64'd1);
		send_item(KIND_RELEASE, 64'd2);
		send_item(KIND_RELEASE, 64'd3);
		send_item(KIND_RELEASE, 64'd4);
		send_item(KIND_UNUSED, '1);
		send_item(KIND_TAKE_ACK, 64'd0);

		// epoch at the top, window sum overflows
		write_epoch('1);
		send_item(KIND_RELEASE, '1);
		send_item(KIND_RELEASE, 64'd0);
		send_item(KIND_TAKE_ACK, 64'd0);

		// window ends exactly at the top
		write_epoch(64'hFFFF_FFFF_FFFF_FEFF);
		send_item(KIND_RELEASE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(KIND_RELEASE, '1);
		send_item(KIND_RELEASE, 64'hFFFF_FFFF_FFFF_FEFF);
		send_item(KIND_RELEASE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(KIND_TAKE_ACK, 64'd0);

		epochs[0] = {$urandom, $urandom};
		epochs[1] = 64'd0;
		epochs[2] = '1 - 64'd299;
		epochs[3] = 64'd1000;
		epochs[4] = {$urandom, $urandom};
		for (int p = 0; p < 5; p++) begin
			write_epoch(epochs[p]);
			if (p == 4)
				idling_on = 1'b0;
			for (int i = 0; i < 190; i++) begin
				if (p == 1 && i == 95)
					drain();
				random_item();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
